// File: hw/rtl/cppm_pkg.sv
// Shared types and constants for the CPPM frame decoder.
`timescale 1ns / 1ps

package cppm_pkg;

  // Timer and register widths
  localparam int TICK_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  // Result tdata layout, lowest bit first
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int IDX_LSB = 0;
  localparam int VAL_LSB = IDX_LSB + IDX_W;
  localparam int CNT_LSB = VAL_LSB + TICK_W;
  localparam int PER_LSB = CNT_LSB + CNT_W;
  localparam int OUT_USED_W = PER_LSB + TICK_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_USED_W;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_GAP = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STALE_LIMIT = 1'b1;

  // Reset values of the registers
  localparam logic [TICK_W-1:0] SYNC_GAP_RESET = 16'd3000;
  localparam logic [TICK_W-1:0] STALE_LIMIT_RESET = 16'd100;

  // Input item kinds
  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result item kinds
  localparam logic KIND_CHAN = 1'b0;
  localparam logic KIND_STALE = 1'b1;

  localparam logic [TICK_W-1:0] AGE_MAX = 16'hFFFF;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic rd_en;       // read channel store at the emit index
    logic load_chan;   // load a channel item into the output register
    logic load_stale;  // load a stale notice into the output register
  } cppm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_req;    // current input closes a frame with channels
    logic stale_req;   // current input is a tick that hits the stale limit
    logic out_free;    // output register can take an item this cycle
    logic last_chan;   // emit index points at the final channel
  } cppm_status_t;

endpackage

// File: hw/rtl/cppm_ctrl.sv
// Controller state machine for the CPPM frame decoder.
`timescale 1ns / 1ps

module cppm_ctrl
  import cppm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  cppm_status_t sts,
  output cppm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SEND  = 4'b0100,
    ST_STALE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.stale_req) begin
            state_nxt = ST_STALE;
          end else if (sts.emit_req) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.load_chan = 1'b1;
          state_nxt = sts.last_chan ? ST_IDLE : ST_READ;
        end
      end
      ST_STALE: begin
        if (sts.out_free) begin
          cmd.load_stale = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/cppm_datapath.sv
// Datapath of the CPPM frame decoder: gap timing, channel store, age, output register.
`timescale 1ns / 1ps

module cppm_datapath
  import cppm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input item fields
  input  logic                   in_mode,
  input  logic [TICK_W-1:0]      in_tick,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast,
  // controller link
  input  cppm_cmd_t              cmd,
  output cppm_status_t           sts
);

  localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);
  localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_CHANNELS);

  logic [TICK_W-1:0] sync_gap_r;
  logic [TICK_W-1:0] stale_limit_r;
  logic [TICK_W-1:0] prev_edge_r;
  logic [TICK_W-1:0] frame_start_r;
  logic [SLOT_W-1:0] slot_r;
  logic              synced_r;
  logic              has_frame_r;
  logic [TICK_W-1:0] age_r;
  logic [TICK_W-1:0] period_r;
  logic [SLOT_W-1:0] cnt_r;
  logic [SLOT_W-1:0] emit_idx_r;
  logic [TICK_W-1:0] rd_data_r;
  logic [TICK_W-1:0] store_r [MAX_CHANNELS];

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic                  out_last_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [TICK_W-1:0]     out_val_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic [TICK_W-1:0]     out_per_r;

  logic [TICK_W-1:0] gap;
  logic [TICK_W-1:0] age_inc;
  logic              is_sync;
  logic              is_capture;
  logic              age_step;
  logic              store_we;

  // Classify the incoming item
  assign gap = in_tick - prev_edge_r;
  assign is_sync = (gap >= sync_gap_r);
  assign is_capture = (in_mode == MODE_CAPTURE);
  assign age_inc = age_r + 16'd1;
  assign age_step = !is_capture && has_frame_r && (age_r != AGE_MAX);
  assign store_we = cmd.accept && is_capture && !is_sync && synced_r && (slot_r < SLOT_MAX);

  assign sts.emit_req = is_capture && is_sync && synced_r && (slot_r != '0);
  assign sts.stale_req = age_step && (age_inc == stale_limit_r);
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.last_chan = (SLOT_W'(emit_idx_r + 1'b1) == cnt_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_gap_r <= SYNC_GAP_RESET;
      stale_limit_r <= STALE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_GAP:    sync_gap_r <= cfg_data;
        REG_STALE_LIMIT: stale_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame tracking and age
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r <= '0;
      frame_start_r <= '0;
      slot_r <= '0;
      synced_r <= 1'b0;
      has_frame_r <= 1'b0;
      age_r <= '0;
      cnt_r <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.accept) begin
        emit_idx_r <= '0;
        if (is_capture) begin
          prev_edge_r <= in_tick;
          if (is_sync) begin
            if (sts.emit_req) begin
              cnt_r <= slot_r;
              has_frame_r <= 1'b1;
              age_r <= '0;
            end
            frame_start_r <= in_tick;
            slot_r <= '0;
            synced_r <= 1'b1;
          end else if (store_we) begin
            slot_r <= SLOT_W'(slot_r + 1'b1);
          end
        end else if (age_step) begin
          age_r <= age_inc;
        end
      end else if (cmd.load_chan) begin
        emit_idx_r <= SLOT_W'(emit_idx_r + 1'b1);
      end
    end
  end

  // Latch the frame period when a frame closes
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit_req) begin
      period_r <= in_tick - frame_start_r;
    end
  end

  // Channel store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[slot_r[ADDR_W-1:0]] <= gap;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_r[emit_idx_r[ADDR_W-1:0]];
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_chan || cmd.load_stale) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_chan) begin
      out_kind_r <= KIND_CHAN;
      out_last_r <= sts.last_chan;
      out_idx_r <= IDX_W'(emit_idx_r);
      out_val_r <= rd_data_r;
      out_cnt_r <= CNT_W'(cnt_r);
      out_per_r <= period_r;
    end else if (cmd.load_stale) begin
      out_kind_r <= KIND_STALE;
      out_last_r <= 1'b1;
      out_idx_r <= '0;
      out_val_r <= '0;
      out_cnt_r <= '0;
      out_per_r <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_kind_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_per_r, out_cnt_r, out_val_r, out_idx_r};

endmodule

// File: hw/rtl/cppm_frame_decoder.sv
// Top level of the CPPM frame decoder: controller plus datapath.
`timescale 1ns / 1ps

// Decodes a CPPM (PPM sum) stream from 16-bit 1 MHz capture timestamps and
// one-millisecond ticks. A capture or tick item is taken while the block is
// idle. An item that closes a frame of N stored channels holds the input off
// while the run goes out: each channel item takes a registered read of the
// channel store, then a load of the output register, which waits while the
// output side stalls. A tick that reaches the stale limit sends one notice
// once the output register is free after the tick is taken.
// The output register lets the last result of a run wait while the next
// input item is accepted. Registers: index 0 is the sync gap in us, index 1
// the stale limit in ms; write them only while the block is idle.
module cppm_frame_decoder
  import cppm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TICK_W-1:0]      in_tdata,  // [15:0] capture_tick
  input  logic                   in_tuser,  // [0] mode
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] chan_index, [19:4] chan_value_us, [24:20] chan_count,
  // [40:25] frame_period, [47:41] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser,  // [0] kind
  output logic                   out_tlast
);

  cppm_cmd_t    cmd;
  cppm_status_t sts;

  assign cfg_ready = 1'b1;

  cppm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cppm_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mode    (in_tuser),
    .in_tick    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: tb/cppm_frame_decoder_tb.sv
// Self-checking testbench for the CPPM frame decoder: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module cppm_frame_decoder_tb;
  import cppm_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_CH = 8;
  localparam int CH_AW = $clog2(MAX_CH);
  localparam int SETTLE_CYCLES = 32;
  localparam int END_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT = 14;
  localparam int CALM_FIRST = 150;
  localparam int CALM_LAST = 270;
  localparam int REPORT_MAX = 10;

  // One decoded result item as the predictor expects it
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] val;
    logic [CNT_W-1:0]  cnt;
    logic [TICK_W-1:0] per;
    logic              last;
  } chan_result_t;

  // Entries of the feed: an input item, a register write, or a wait for an empty pipe
  typedef enum logic [1:0] {
    FEED_ITEM,
    FEED_REG,
    FEED_DRAIN
  } feed_op_t;

  typedef struct {
    feed_op_t               op;
    logic                   mode;
    logic [TICK_W-1:0]      tick;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } feed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TICK_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  feed_t        feed_q[$];
  chan_result_t due_results[$];

  // Predictor copy of the decoder state and registers
  logic [TICK_W-1:0] m_sync_gap;
  logic [TICK_W-1:0] m_stale_limit;
  logic [TICK_W-1:0] m_prev_edge;
  logic [TICK_W-1:0] m_frame_start;
  logic [4:0]        m_next_slot;
  logic              m_synced;
  logic              m_has_frame;
  logic [TICK_W-1:0] m_age;
  logic [TICK_W-1:0] m_store[MAX_CH];

  // Stimulus generation state
  logic [TICK_W-1:0] gen_time;
  int                gen_sync;

  int cycle_cnt = 0;
  int settle_cnt = 0;
  int items_taken = 0;
  int reg_writes = 0;
  int results_seen = 0;
  int frames_due = 0;
  int stale_due = 0;
  int err_cnt = 0;

  cppm_frame_decoder #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // No idling on either side inside this window of accepted items
  function automatic bit calm_window();
    return items_taken >= CALM_FIRST && items_taken < CALM_LAST;
  endfunction

  function automatic string fmt_result(input chan_result_t r);
    return $sformatf("kind %0d idx %0d val %0d cnt %0d per %0d last %0d",
                     r.kind, r.idx, r.val, r.cnt, r.per, r.last);
  endfunction

  task automatic reset_decoder_model();
    m_sync_gap = SYNC_GAP_RESET;
    m_stale_limit = STALE_LIMIT_RESET;
    m_prev_edge = '0;
    m_frame_start = '0;
    m_next_slot = '0;
    m_synced = 1'b0;
    m_has_frame = 1'b0;
    m_age = '0;
  endtask

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_SYNC_GAP) begin
      m_sync_gap = val;
    end else if (idx == REG_STALE_LIMIT) begin
      m_stale_limit = val;
    end
  endtask

  // Advance the decoder state by one item and queue the results it causes
  task automatic decode_item(input logic mode, input logic [TICK_W-1:0] tick);
    logic [TICK_W-1:0] gap;
    logic [TICK_W-1:0] period;
    int                cnt;
    int                i;
    chan_result_t      r;
    if (mode == MODE_TICK) begin
      if (m_has_frame && m_age != AGE_MAX) begin
        m_age = m_age + 1'b1;
        if (m_age == m_stale_limit) begin
          r = '0;
          r.kind = KIND_STALE;
          r.last = 1'b1;
          due_results.push_back(r);
          stale_due++;
        end
      end
    end else begin
      gap = tick - m_prev_edge;
      m_prev_edge = tick;
      if (gap >= m_sync_gap) begin
        // sync edge: close the frame if it holds channels
        if (m_synced && m_next_slot != 0) begin
          period = tick - m_frame_start;
          cnt = (m_next_slot > MAX_CH) ? MAX_CH : m_next_slot;
          for (i = 0; i < cnt; i++) begin
            r.kind = KIND_CHAN;
            r.idx = i[IDX_W-1:0];
            r.val = m_store[i[CH_AW-1:0]];
            r.cnt = cnt[CNT_W-1:0];
            r.per = period;
            r.last = (i + 1 == cnt);
            due_results.push_back(r);
          end
          frames_due++;
          m_has_frame = 1'b1;
          m_age = '0;
        end
        m_frame_start = tick;
        m_next_slot = '0;
        m_synced = 1'b1;
      end else if (m_synced && m_next_slot < MAX_CH) begin
        m_store[m_next_slot[CH_AW-1:0]] = gap;
        m_next_slot = m_next_slot + 1'b1;
      end
    end
  endtask

  task automatic push_item(input logic mode, input logic [TICK_W-1:0] tick);
    feed_t f;
    f.op = FEED_ITEM;
    f.mode = mode;
    f.tick = tick;
    f.reg_idx = '0;
    f.reg_val = '0;
    feed_q.push_back(f);
  endtask

  task automatic push_tick();
    push_item(MODE_TICK, TICK_W'($urandom));
  endtask

  task automatic push_gap(input int gap);
    gen_time = gen_time + gap[TICK_W-1:0];
    push_item(MODE_CAPTURE, gen_time);
  endtask

  task automatic push_drain();
    feed_t f;
    f.op = FEED_DRAIN;
    f.mode = MODE_CAPTURE;
    f.tick = '0;
    f.reg_idx = '0;
    f.reg_val = '0;
    feed_q.push_back(f);
  endtask

  task automatic push_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    feed_t f;
    f.op = FEED_REG;
    f.mode = MODE_CAPTURE;
    f.tick = '0;
    f.reg_idx = idx;
    f.reg_val = val[CFG_DATA_W-1:0];
    feed_q.push_back(f);
  endtask

  // Write both registers once the pipe has gone quiet
  task automatic set_registers(input int sync_gap, input int stale_limit);
    push_drain();
    push_reg(REG_SYNC_GAP, sync_gap);
    push_reg(REG_STALE_LIMIT, stale_limit);
    gen_sync = sync_gap;
  endtask

  function automatic int pick_sync_gap();
    if ($urandom_range(99) < 30) return gen_sync;
    return $urandom_range(65535, gen_sync);
  endfunction

  // Assumes a nonzero sync gap
  function automatic int pick_chan_gap();
    int r;
    r = $urandom_range(99);
    if (r < 12) return gen_sync - 1;
    if (r < 20) return 0;
    if (gen_sync > 2200 && r < 80) return $urandom_range(2200, 700);
    return $urandom_range(gen_sync - 1, 0);
  endfunction

  // Mostly well-formed frames with random content, plus tick bursts and noise
  task automatic random_phase(input int budget);
    int used;
    int pick;
    int n;
    int k;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_gap(pick_sync_gap());
        used++;
        if (gen_sync != 0) begin
          n = $urandom_range(MAX_CH + 2);
          for (k = 0; k < n; k++) begin
            push_gap(pick_chan_gap());
            used++;
            if ($urandom_range(99) < 8) begin
              push_tick();
              used++;
            end
          end
        end
      end else if (pick < 84) begin
        n = $urandom_range(15);
        for (k = 0; k < n; k++) push_tick();
        used += n + 1;
      end else if (pick < 97) begin
        gen_time = TICK_W'($urandom);
        push_item(MODE_CAPTURE, gen_time);
        used++;
      end else begin
        push_drain();
        used++;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
  endtask

  // Driver: present feed entries, track acceptance, feed the predictor
  always @(posedge clk) begin : drive_proc
    logic                   nv_in_valid;
    logic                   nv_cfg_valid;
    feed_t                  f;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_item(in_tuser, in_tdata);
        items_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        reg_writes++;
      end
      if ((in_tvalid && !in_tready) || (cfg_valid && !cfg_ready)) begin
        // hold the item until it is taken
      end else begin
        nv_in_valid = 1'b0;
        nv_cfg_valid = 1'b0;
        if (feed_q.size() != 0) begin
          f = feed_q[0];
          case (f.op)
            FEED_DRAIN: begin
              if (due_results.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt = 0;
                void'(feed_q.pop_front());
              end else begin
                settle_cnt++;
              end
            end
            FEED_REG: begin
              void'(feed_q.pop_front());
              nv_cfg_valid = 1'b1;
              cfg_index <= f.reg_idx;
              cfg_data <= f.reg_val;
            end
            default: begin
              if (calm_window() || $urandom_range(99) >= IDLE_PCT) begin
                void'(feed_q.pop_front());
                nv_in_valid = 1'b1;
                in_tdata <= f.tick;
                in_tuser <= f.mode;
              end
            end
          endcase
        end
        in_tvalid <= nv_in_valid;
        cfg_valid <= nv_cfg_valid;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : watch_proc
    chan_result_t want;
    chan_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.kind = out_tuser;
        got.idx = out_tdata[IDX_LSB +: IDX_W];
        got.val = out_tdata[VAL_LSB +: TICK_W];
        got.cnt = out_tdata[CNT_LSB +: CNT_W];
        got.per = out_tdata[PER_LSB +: TICK_W];
        got.last = out_tlast;
        if (due_results.size() == 0) begin
          note_mismatch({"unexpected result ", fmt_result(got)});
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.idx !== want.idx || got.val !== want.val ||
              got.cnt !== want.cnt || got.per !== want.per || got.last !== want.last ||
              out_tdata[OUT_USED_W +: OUT_PAD_W] !== '0) begin
            note_mismatch($sformatf("expected %s, got %s pad %h",
                                    fmt_result(want), fmt_result(got),
                                    out_tdata[OUT_USED_W +: OUT_PAD_W]));
          end
        end
      end
      out_tready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d results still due", due_results.size());
      $display("[cppm_frame_decoder] ERROR");
      $finish;
    end
  end

  initial begin : stim_proc
    int k;
    reset_decoder_model();
    gen_sync = SYNC_GAP_RESET;

    // Directed: unsynced gap, tick with no frame, first sync, empty frame
    push_item(MODE_CAPTURE, 16'd100);
    push_tick();
    push_item(MODE_CAPTURE, 16'd3100);
    push_item(MODE_CAPTURE, 16'd6100);
    // zero gap, longest short gap, then a sync at the top of the timer
    push_item(MODE_CAPTURE, 16'd6100);
    push_item(MODE_CAPTURE, 16'd9099);
    push_item(MODE_CAPTURE, 16'hFFFF);
    // wrap to zero, then overfill the store so the extra channels drop
    push_item(MODE_CAPTURE, 16'd0);
    gen_time = 16'd0;
    for (k = 0; k < MAX_CH + 1; k++) push_gap(1500);
    push_gap(5000);
    for (k = 0; k < 3; k++) push_tick();

    // Directed: widest sync gap and a tiny stale limit
    set_registers(65535, 2);
    push_gap(65535);
    push_gap(100);
    push_gap(65535);
    for (k = 0; k < 3; k++) push_tick();

    // Random phases over a spread of register settings
    set_registers(2500, 5);
    random_phase(90);
    set_registers(65535, 1);
    random_phase(40);
    set_registers(1, 65535);
    random_phase(40);
    set_registers(0, 0);
    random_phase(25);
    set_registers(3000, 3);
    random_phase(120);
    set_registers(1000, 12);
    random_phase(80);

    // Lower the stale limit below the current frame age
    push_gap(1500);
    push_gap(400);
    push_gap(1500);
    for (k = 0; k < 8; k++) push_tick();
    set_registers(1000, 4);
    for (k = 0; k < 10; k++) push_tick();

    // Longest stale limit: close frames and age them without a notice
    set_registers(3000, 65535);
    push_gap(4000);
    push_gap(1000);
    push_gap(1200);
    push_gap(5000);
    for (k = 0; k < 3; k++) push_tick();
    push_gap(5000);
    push_gap(900);
    push_gap(5000);
    for (k = 0; k < 3; k++) push_tick();

    // Release reset, then run the feed dry and let the pipe settle
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (feed_q.size() != 0 || in_tvalid || cfg_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (due_results.size() != 0) note_mismatch("expectations left over at the end");

    $display("run covered %0d input items and %0d register writes in %0d cycles",
             items_taken, reg_writes, cycle_cnt);
    $display("checked %0d results: %0d frames closed, %0d stale notices, %0d mismatches",
             results_seen, frames_due, stale_due, err_cnt);
    if (err_cnt == 0) begin
      $display("[cppm_frame_decoder] OK");
    end else begin
      $display("[cppm_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/cppm_pkg.sv
hw/rtl/cppm_ctrl.sv
hw/rtl/cppm_datapath.sv
hw/rtl/cppm_frame_decoder.sv
tb/cppm_frame_decoder_tb.sv
